/* sv/brx_pkg.sv */
// brx_pkg: word types, character codes and sizes shared by the
// basic-to-extended regex translator. Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package brx_pkg;

   localparam int CharWidth  = 21;
   localparam int MaxRun     = 9;
   localparam int CountWidth = $clog2(MaxRun + 1);

   typedef logic [CharWidth-1:0] char_type;

   localparam char_type ChBackslash = char_type'(8'h5C);
   localparam char_type ChCaret     = char_type'(8'h5E);
   localparam char_type ChStar      = char_type'(8'h2A);
   localparam char_type ChDollar    = char_type'(8'h24);
   localparam char_type ChBar       = char_type'(8'h7C);
   localparam char_type ChPlus      = char_type'(8'h2B);
   localparam char_type ChQuestion  = char_type'(8'h3F);
   localparam char_type ChOpenPar   = char_type'(8'h28);
   localparam char_type ChClosePar  = char_type'(8'h29);
   localparam char_type ChOpenBrace = char_type'(8'h7B);
   localparam char_type ChCloseBrc  = char_type'(8'h7D);
   localparam char_type ChLess      = char_type'(8'h3C);
   localparam char_type ChGreater   = char_type'(8'h3E);
   localparam char_type ChOpenBrk   = char_type'(8'h5B);
   localparam char_type ChCloseBrk  = char_type'(8'h5D);
   localparam char_type ChColon     = char_type'(8'h3A);
   localparam char_type ChDot       = char_type'(8'h2E);
   localparam char_type ChEquals    = char_type'(8'h3D);

   typedef struct packed {
      logic [CharWidth-1:0] code_point;
      logic                 end_of_pattern;
   } req_word_type;

   typedef struct packed {
      logic [CharWidth-1:0] out_code_point;
      logic                 run_last;
      logic                 pattern_end;
   } rsp_word_type;

   // characters produced by one input word, first at index 0
   typedef struct packed {
      logic [MaxRun-1:0][CharWidth-1:0] chars;
      logic [CountWidth-1:0]            count;
      logic                             pattern_end;
   } run_type;

endpackage

`default_nettype wire

/* sv/brx_xlate.sv */
// brx_xlate: translation state and the single-pass rewrite of one word
// into a run of up to nine characters. Depends on brx_pkg.
`timescale 1ns / 1ps
`default_nettype none

module brx_xlate (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  load,
   input  wire brx_pkg::req_word_type item,
   output brx_pkg::run_type           run
);

   localparam logic [2:0] PhOut   = 3'd0;
   localparam logic [2:0] PhOpen  = 3'd1;
   localparam logic [2:0] PhCaret = 3'd2;
   localparam logic [2:0] PhBody  = 3'd3;
   localparam logic [2:0] PhInner = 3'd4;
   localparam logic [2:0] PhForm  = 3'd5;
   localparam logic [2:0] PhDelim = 3'd6;

   localparam logic [1:0] ScNone  = 2'd0;
   localparam logic [1:0] ScCaret = 2'd1;
   localparam logic [1:0] ScOther = 2'd2;

   localparam logic [1:0] CdNone  = 2'd0;
   localparam logic [1:0] CdColon = 2'd1;
   localparam logic [1:0] CdDot   = 2'd2;
   localparam logic [1:0] CdEqual = 2'd3;

   localparam logic [1:0] DhNone  = 2'd0;
   localparam logic [1:0] DhHeld  = 2'd1;
   localparam logic [1:0] DhSlash = 2'd2;

   logic       bs_ff, bs_in;
   logic [1:0] sc_ff, sc_in;
   logic [2:0] ph_ff, ph_in;
   logic [1:0] cd_ff, cd_in;
   logic [1:0] dh_ff, dh_in;

   logic [brx_pkg::MaxRun-1:0][brx_pkg::CharWidth-1:0] ob;
   logic [brx_pkg::CountWidth-1:0]                     oc;
   logic                                               do_plain;
   logic                                               last;
   brx_pkg::char_type                                  c;
   brx_pkg::char_type                                  delim;

   assign c    = item.code_point;
   assign last = item.end_of_pattern;

   always_comb begin
      bs_in    = bs_ff;
      sc_in    = sc_ff;
      ph_in    = ph_ff;
      cd_in    = cd_ff;
      dh_in    = dh_ff;
      ob       = '0;
      oc       = '0;
      do_plain = 1'b0;
      delim    = brx_pkg::ChEquals;

      if (ph_ff != PhOut) begin
         // bracket text is copied as it stands
         ob[oc] = c; oc = oc + 1'b1;
         unique case (ph_ff) inside
            PhOpen, PhCaret: begin
               if (ph_ff == PhOpen && c == brx_pkg::ChCaret) begin
                  ph_in = PhCaret;
               end else if (c == brx_pkg::ChCloseBrk) begin
                  ph_in = PhBody;
               end else if (c == brx_pkg::ChOpenBrk) begin
                  ph_in = PhInner;
               end else begin
                  ph_in = PhBody;
               end
            end
            PhInner: begin
               if (c == brx_pkg::ChColon) begin
                  cd_in = CdColon;
                  ph_in = PhForm;
               end else if (c == brx_pkg::ChDot) begin
                  cd_in = CdDot;
                  ph_in = PhForm;
               end else if (c == brx_pkg::ChEquals) begin
                  cd_in = CdEqual;
                  ph_in = PhForm;
               end else begin
                  ph_in = PhBody;
               end
            end
            PhForm: begin
               if (cd_ff == CdColon) begin
                  delim = brx_pkg::ChColon;
               end else if (cd_ff == CdDot) begin
                  delim = brx_pkg::ChDot;
               end
               if (cd_ff != CdNone && c == delim) begin
                  ph_in = PhDelim;
               end
            end
            PhDelim: begin
               ph_in = (c == brx_pkg::ChCloseBrk) ? PhBody : PhForm;
            end
            default: begin
               if (c == brx_pkg::ChCloseBrk) begin
                  ph_in = PhOut;
                  sc_in = ScOther;
                  bs_in = 1'b0;
               end else if (c == brx_pkg::ChOpenBrk) begin
                  ph_in = PhInner;
               end else begin
                  ph_in = PhBody;
               end
            end
         endcase
      end else if (dh_ff == DhHeld) begin
         if (c == brx_pkg::ChBackslash && !last) begin
            dh_in = DhSlash;
            bs_in = 1'b1;
            sc_in = ScOther;
         end else begin
            dh_in = DhNone;
            ob[oc] = brx_pkg::ChBackslash; oc = oc + 1'b1;
            ob[oc] = brx_pkg::ChDollar;    oc = oc + 1'b1;
            do_plain = 1'b1;
         end
      end else if (dh_ff == DhSlash) begin
         // dollar stays bare only before an escaped close paren
         dh_in = DhNone;
         if (c != brx_pkg::ChClosePar) begin
            ob[oc] = brx_pkg::ChBackslash; oc = oc + 1'b1;
         end
         ob[oc] = brx_pkg::ChDollar; oc = oc + 1'b1;
         bs_in = 1'b1;
         do_plain = 1'b1;
      end else begin
         do_plain = 1'b1;
      end

      if (do_plain) begin
         if (bs_in) begin
            bs_in = 1'b0;
            sc_in = ScOther;
            if (c == brx_pkg::ChOpenPar) begin
               ob[oc] = c; oc = oc + 1'b1;
               sc_in = ScNone;
            end else if (c == brx_pkg::ChClosePar || c == brx_pkg::ChOpenBrace ||
                         c == brx_pkg::ChCloseBrc) begin
               ob[oc] = c; oc = oc + 1'b1;
            end else if (c == brx_pkg::ChLess || c == brx_pkg::ChGreater) begin
               // word boundary class
               ob[oc] = brx_pkg::ChOpenBrk;  oc = oc + 1'b1;
               ob[oc] = brx_pkg::ChOpenBrk;  oc = oc + 1'b1;
               ob[oc] = brx_pkg::ChColon;    oc = oc + 1'b1;
               ob[oc] = c;                   oc = oc + 1'b1;
               ob[oc] = brx_pkg::ChColon;    oc = oc + 1'b1;
               ob[oc] = brx_pkg::ChCloseBrk; oc = oc + 1'b1;
               ob[oc] = brx_pkg::ChCloseBrk; oc = oc + 1'b1;
            end else begin
               ob[oc] = brx_pkg::ChBackslash; oc = oc + 1'b1;
               ob[oc] = c;                    oc = oc + 1'b1;
            end
         end else if (c == brx_pkg::ChBackslash) begin
            bs_in = 1'b1;
            sc_in = ScOther;
         end else if (c == brx_pkg::ChCaret) begin
            if (sc_in == ScNone) begin
               ob[oc] = c; oc = oc + 1'b1;
               sc_in = ScCaret;
            end else begin
               ob[oc] = brx_pkg::ChBackslash; oc = oc + 1'b1;
               ob[oc] = c;                    oc = oc + 1'b1;
               sc_in = ScOther;
            end
         end else if (c == brx_pkg::ChStar) begin
            if (sc_in == ScNone || sc_in == ScCaret) begin
               ob[oc] = brx_pkg::ChBackslash; oc = oc + 1'b1;
            end
            ob[oc] = c; oc = oc + 1'b1;
            sc_in = ScOther;
         end else if (c == brx_pkg::ChDollar) begin
            sc_in = ScOther;
            if (last) begin
               ob[oc] = c; oc = oc + 1'b1;
            end else begin
               dh_in = DhHeld;
            end
         end else if (c == brx_pkg::ChBar || c == brx_pkg::ChPlus ||
                      c == brx_pkg::ChQuestion || c == brx_pkg::ChOpenPar ||
                      c == brx_pkg::ChClosePar || c == brx_pkg::ChOpenBrace ||
                      c == brx_pkg::ChCloseBrc) begin
            ob[oc] = brx_pkg::ChBackslash; oc = oc + 1'b1;
            ob[oc] = c;                    oc = oc + 1'b1;
            sc_in = ScOther;
         end else if (c == brx_pkg::ChOpenBrk) begin
            ob[oc] = c; oc = oc + 1'b1;
            ph_in = PhOpen;
         end else begin
            ob[oc] = c; oc = oc + 1'b1;
            sc_in = ScOther;
         end
      end

      if (last) begin
         // trailing backslash is kept, then a fresh pattern starts
         if (ph_in == PhOut && bs_in) begin
            ob[oc] = brx_pkg::ChBackslash; oc = oc + 1'b1;
         end
         bs_in = 1'b0;
         sc_in = ScNone;
         ph_in = PhOut;
         cd_in = CdNone;
         dh_in = DhNone;
      end
   end

   assign run.chars       = ob;
   assign run.count       = oc;
   assign run.pattern_end = last;

   always_ff @(posedge clock) begin
      if (reset) begin
         bs_ff <= 1'b0;
         sc_ff <= ScNone;
         ph_ff <= PhOut;
         cd_ff <= CdNone;
         dh_ff <= DhNone;
      end else if (load) begin
         bs_ff <= bs_in;
         sc_ff <= sc_in;
         ph_ff <= ph_in;
         cd_ff <= cd_in;
         dh_ff <= dh_in;
      end
   end

endmodule

`default_nettype wire

/* sv/brx_emit.sv */
// brx_emit: result buffer that holds one run of characters and shifts
// them out one word per cycle while rsp_stall is low. Depends on brx_pkg.
`timescale 1ns / 1ps
`default_nettype none

module brx_emit (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             load,
   input  wire brx_pkg::run_type run,
   output logic                  free,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output brx_pkg::rsp_word_type rsp_data
);

   logic [brx_pkg::MaxRun-1:0][brx_pkg::CharWidth-1:0] chars_ff, chars_in;
   logic [brx_pkg::CountWidth-1:0]                     rem_ff, rem_in;
   logic                                               end_ff, end_in;
   logic                                               take;
   logic                                               final_word;

   assign rsp_valid  = (rem_ff != '0);
   assign take       = rsp_valid && !rsp_stall;
   assign final_word = (rem_ff == brx_pkg::CountWidth'(1));
   // buffer can take a new run once its last word leaves
   assign free       = !rsp_valid || (final_word && !rsp_stall);

   always_comb begin
      chars_in = chars_ff;
      rem_in   = rem_ff;
      end_in   = end_ff;
      if (load) begin
         chars_in = run.chars;
         rem_in   = run.count;
         end_in   = run.pattern_end;
      end else if (take) begin
         chars_in = {brx_pkg::CharWidth'(0), chars_ff[brx_pkg::MaxRun-1:1]};
         rem_in   = rem_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rem_ff <= '0;
      end else begin
         rem_ff <= rem_in;
      end
   end

   always_ff @(posedge clock) begin
      chars_ff <= chars_in;
      end_ff   <= end_in;
   end

   assign rsp_data.out_code_point = chars_ff[0];
   assign rsp_data.run_last       = final_word;
   assign rsp_data.pattern_end    = final_word && end_ff;

endmodule

`default_nettype wire

/* sv/basic_to_extended_regex_translator.sv */
// basic_to_extended_regex_translator: top level with the input register,
// the translator stage and the result buffer. Depends on brx_pkg,
// brx_xlate and brx_emit.
//
// usage: a basic regular expression arrives on req_* one code point per
// word, end_of_pattern set on its final character. The extended
// expression leaves on rsp_* one code point per word; run_last marks the
// last word caused by an input word and pattern_end the last word of the
// whole translated pattern. An input word that causes no output (a
// backslash, a held dollar) is taken silently.
// path: a word is held in the input register until the result buffer is
// free, and its first result is presented once the buffer has loaded it.
// throughput: one word per cycle while each word gives at most one
// character and rsp_stall is low; a longer run (at most nine characters,
// for an escaped dollar followed by a word boundary) holds the result
// buffer until its last word leaves, and req_stall is raised once the
// next word waits behind it. A stall on rsp_stall holds the current result
// and, once the input register is full, back-pressures req_*.
// reset (synchronous) empties both registers and returns the translator
// to the start of a pattern; no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none

module basic_to_extended_regex_translator (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire brx_pkg::req_word_type req_data,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output brx_pkg::rsp_word_type      rsp_data
);

   logic                  in_valid_ff, in_valid_in;
   brx_pkg::req_word_type in_item_ff, in_item_in;
   logic                  buf_free;
   logic                  load;
   logic                  advance;
   brx_pkg::run_type      run;

   assign load      = in_valid_ff && buf_free;
   assign advance   = !in_valid_ff || load;
   assign req_stall = !advance;

   always_comb begin
      in_valid_in = in_valid_ff;
      in_item_in  = in_item_ff;
      if (advance) begin
         in_valid_in = req_valid;
         in_item_in  = req_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_item_ff <= in_item_in;
   end

   brx_xlate u_xlate (
      .clock (clock),
      .reset (reset),
      .load  (load),
      .item  (in_item_ff),
      .run   (run)
   );

   brx_emit u_emit (
      .clock     (clock),
      .reset     (reset),
      .load      (load),
      .run       (run),
      .free      (buf_free),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

/* tb/sv/basic_to_extended_regex_translator_tb.sv */
// testbench for basic_to_extended_regex_translator: directed and random basic regexes
// in, every translated word checked against a local translation model.
// depends on brx_pkg and the translator rtl.
`timescale 1ns / 1ps

module basic_to_extended_regex_translator_tb;

   localparam int CycleLimit = 300000;

   typedef enum logic [2:0] {
      PhOut, PhOpen, PhCaret, PhBody, PhInner, PhForm, PhDelim
   } phase_type;
   typedef enum logic [1:0] {CtxEmpty, CtxCaret, CtxOther} context_type;
   typedef enum logic [1:0] {DelimNone, DelimColon, DelimDot, DelimEquals} delim_type;
   typedef enum logic [1:0] {HoldNone, HoldDollar, HoldDollarEsc} hold_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   brx_pkg::req_word_type req_data = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   brx_pkg::rsp_word_type rsp_data;

   // translation state
   logic         esc_pending = 1'b0;
   context_type  start_ctx = CtxEmpty;
   phase_type    phase = PhOut;
   delim_type    form_delim = DelimNone;
   hold_type     dollar_hold = HoldNone;

   brx_pkg::char_type     run_chars[$];
   brx_pkg::rsp_word_type pending_words[$];
   brx_pkg::char_type     pattern_chars[$];

   logic         steady = 1'b0;
   int           random_sent = 0;
   int           mismatch_count = 0;
   int           cycle_count = 0;

   basic_to_extended_regex_translator dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always #6 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CycleLimit) begin
         $display("FAILURE");
         $finish;
      end
   end

   always @(negedge clock) begin
      rsp_stall <= !steady && ($urandom_range(0, 99) < 38);
   end

   function automatic void clear_translator();
      esc_pending = 1'b0;
      start_ctx   = CtxEmpty;
      phase       = PhOut;
      form_delim  = DelimNone;
      dollar_hold = HoldNone;
   endfunction

   // body character: ']' closes, '[' may open a nested form
   function automatic void close_or_nest(brx_pkg::char_type c);
      if (c == brx_pkg::ChCloseBrk) begin
         phase       = PhOut;
         start_ctx   = CtxOther;
         esc_pending = 1'b0;
      end else if (c == brx_pkg::ChOpenBrk) begin
         phase = PhInner;
      end else begin
         phase = PhBody;
      end
   endfunction

   function automatic void bracket_step(brx_pkg::char_type c);
      brx_pkg::char_type delim_char;
      run_chars.push_back(c);
      case (phase)
         PhOpen: begin
            if (c == brx_pkg::ChCaret) phase = PhCaret;
            else if (c == brx_pkg::ChCloseBrk) phase = PhBody;
            else close_or_nest(c);
         end
         PhCaret: begin
            if (c == brx_pkg::ChCloseBrk) phase = PhBody;
            else close_or_nest(c);
         end
         PhInner: begin
            if (c == brx_pkg::ChColon) begin
               form_delim = DelimColon;
               phase = PhForm;
            end else if (c == brx_pkg::ChDot) begin
               form_delim = DelimDot;
               phase = PhForm;
            end else if (c == brx_pkg::ChEquals) begin
               form_delim = DelimEquals;
               phase = PhForm;
            end else begin
               phase = PhBody;
            end
         end
         PhForm: begin
            delim_char = (form_delim == DelimColon) ? brx_pkg::ChColon :
                         (form_delim == DelimDot) ? brx_pkg::ChDot : brx_pkg::ChEquals;
            if (form_delim != DelimNone && c == delim_char) phase = PhDelim;
         end
         PhDelim: begin
            phase = (c == brx_pkg::ChCloseBrk) ? PhBody : PhForm;
         end
         default: begin
            close_or_nest(c);
         end
      endcase
   endfunction

   function automatic void outside_step(brx_pkg::char_type c, logic eop);
      if (esc_pending) begin
         esc_pending = 1'b0;
         start_ctx = CtxOther;
         if (c == brx_pkg::ChOpenPar) begin
            run_chars.push_back(c);
            start_ctx = CtxEmpty;
         end else if (c == brx_pkg::ChClosePar || c == brx_pkg::ChOpenBrace ||
                      c == brx_pkg::ChCloseBrc) begin
            run_chars.push_back(c);
         end else if (c == brx_pkg::ChLess || c == brx_pkg::ChGreater) begin
            // word boundary becomes a seven-character class
            run_chars.push_back(brx_pkg::ChOpenBrk);
            run_chars.push_back(brx_pkg::ChOpenBrk);
            run_chars.push_back(brx_pkg::ChColon);
            run_chars.push_back(c);
            run_chars.push_back(brx_pkg::ChColon);
            run_chars.push_back(brx_pkg::ChCloseBrk);
            run_chars.push_back(brx_pkg::ChCloseBrk);
         end else begin
            run_chars.push_back(brx_pkg::ChBackslash);
            run_chars.push_back(c);
         end
      end else begin
         case (c) inside
            brx_pkg::ChBackslash: begin
               esc_pending = 1'b1;
               start_ctx = CtxOther;
            end
            brx_pkg::ChCaret: begin
               if (start_ctx == CtxEmpty) begin
                  run_chars.push_back(c);
                  start_ctx = CtxCaret;
               end else begin
                  run_chars.push_back(brx_pkg::ChBackslash);
                  run_chars.push_back(c);
                  start_ctx = CtxOther;
               end
            end
            brx_pkg::ChStar: begin
               if (start_ctx == CtxEmpty || start_ctx == CtxCaret)
                  run_chars.push_back(brx_pkg::ChBackslash);
               run_chars.push_back(c);
               start_ctx = CtxOther;
            end
            brx_pkg::ChDollar: begin
               start_ctx = CtxOther;
               if (eop) run_chars.push_back(c);
               else dollar_hold = HoldDollar;
            end
            brx_pkg::ChBar, brx_pkg::ChPlus, brx_pkg::ChQuestion,
            brx_pkg::ChOpenPar, brx_pkg::ChClosePar,
            brx_pkg::ChOpenBrace, brx_pkg::ChCloseBrc: begin
               run_chars.push_back(brx_pkg::ChBackslash);
               run_chars.push_back(c);
               start_ctx = CtxOther;
            end
            brx_pkg::ChOpenBrk: begin
               run_chars.push_back(c);
               phase = PhOpen;
            end
            default: begin
               run_chars.push_back(c);
               start_ctx = CtxOther;
            end
         endcase
      end
   endfunction

   // works out the words one accepted input word gives and queues them
   function automatic void translate_char(brx_pkg::char_type c, logic eop);
      brx_pkg::rsp_word_type w;
      run_chars.delete();
      if (phase != PhOut) begin
         bracket_step(c);
      end else if (dollar_hold == HoldDollar) begin
         if (c == brx_pkg::ChBackslash && !eop) begin
            dollar_hold = HoldDollarEsc;
            esc_pending = 1'b1;
            start_ctx = CtxOther;
         end else begin
            dollar_hold = HoldNone;
            run_chars.push_back(brx_pkg::ChBackslash);
            run_chars.push_back(brx_pkg::ChDollar);
            outside_step(c, eop);
         end
      end else if (dollar_hold == HoldDollarEsc) begin
         // a dollar before an escaped close paren ends a group and stays bare
         dollar_hold = HoldNone;
         if (c != brx_pkg::ChClosePar) run_chars.push_back(brx_pkg::ChBackslash);
         run_chars.push_back(brx_pkg::ChDollar);
         esc_pending = 1'b1;
         outside_step(c, eop);
      end else begin
         outside_step(c, eop);
      end
      if (eop) begin
         if (phase == PhOut && esc_pending) run_chars.push_back(brx_pkg::ChBackslash);
         clear_translator();
      end
      for (int i = 0; i < run_chars.size(); i++) begin
         w.out_code_point = run_chars[i];
         w.run_last       = (i == run_chars.size() - 1);
         w.pattern_end    = (i == run_chars.size() - 1) && eop;
         pending_words.push_back(w);
      end
   endfunction

   always @(posedge clock) begin : check_words
      brx_pkg::rsp_word_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_words.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("unexpected word: char %h run_last %b pattern_end %b",
                        rsp_data.out_code_point, rsp_data.run_last, rsp_data.pattern_end);
         end else begin
            want = pending_words.pop_front();
            if (rsp_data.out_code_point !== want.out_code_point ||
                rsp_data.run_last !== want.run_last ||
                rsp_data.pattern_end !== want.pattern_end) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("mismatch: expected char %h run_last %b pattern_end %b, got %h %b %b",
                           want.out_code_point, want.run_last, want.pattern_end,
                           rsp_data.out_code_point, rsp_data.run_last, rsp_data.pattern_end);
            end
         end
      end
   end

   // entered and left just after a falling edge
   task automatic send_char(input brx_pkg::char_type cp, input logic eop);
      while (!steady && $urandom_range(0, 99) < 38) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= {cp, eop};
      @(posedge clock);
      while (req_stall) @(posedge clock);
      translate_char(cp, eop);
      @(negedge clock);
   endtask

   task automatic send_text(input string s, input logic mark_end);
      for (int i = 0; i < s.len(); i++)
         send_char(brx_pkg::char_type'(s[i]), mark_end && (i == s.len() - 1));
   endtask

   function automatic brx_pkg::char_type pick_special();
      case ($urandom_range(0, 17))
         0:       return brx_pkg::ChBackslash;
         1:       return brx_pkg::ChCaret;
         2:       return brx_pkg::ChStar;
         3:       return brx_pkg::ChDollar;
         4:       return brx_pkg::ChBar;
         5:       return brx_pkg::ChPlus;
         6:       return brx_pkg::ChQuestion;
         7:       return brx_pkg::ChOpenPar;
         8:       return brx_pkg::ChClosePar;
         9:       return brx_pkg::ChOpenBrace;
         10:      return brx_pkg::ChCloseBrc;
         11:      return brx_pkg::ChLess;
         12:      return brx_pkg::ChGreater;
         13:      return brx_pkg::ChOpenBrk;
         14:      return brx_pkg::ChCloseBrk;
         15:      return brx_pkg::ChColon;
         16:      return brx_pkg::ChDot;
         default: return brx_pkg::ChEquals;
      endcase
   endfunction

   function automatic brx_pkg::char_type pick_plain();
      case ($urandom_range(0, 4)) inside
         0, 1:    return brx_pkg::char_type'($urandom_range(8'h61, 8'h7A));
         2:       return brx_pkg::char_type'($urandom_range(0, 8'h7F));
         3:       return brx_pkg::char_type'($urandom_range(8'h80, 21'h10FFFF));
         default: return brx_pkg::char_type'($urandom_range(21'h110000, 21'h1FFFFF));
      endcase
   endfunction

   function automatic brx_pkg::char_type pick_any();
      return $urandom_range(0, 1) ? pick_special() : pick_plain();
   endfunction

   function automatic void add_bracket();
      brx_pkg::char_type delim;
      pattern_chars.push_back(brx_pkg::ChOpenBrk);
      if ($urandom_range(0, 2) == 0) pattern_chars.push_back(brx_pkg::ChCaret);
      if ($urandom_range(0, 2) == 0) pattern_chars.push_back(brx_pkg::ChCloseBrk);
      repeat ($urandom_range(0, 3)) begin
         case ($urandom_range(0, 3))
            0: begin
               case ($urandom_range(0, 2))
                  0:       delim = brx_pkg::ChColon;
                  1:       delim = brx_pkg::ChDot;
                  default: delim = brx_pkg::ChEquals;
               endcase
               pattern_chars.push_back(brx_pkg::ChOpenBrk);
               pattern_chars.push_back(delim);
               repeat ($urandom_range(0, 2))
                  pattern_chars.push_back($urandom_range(0, 3) == 0 ?
                                          brx_pkg::ChCloseBrk : pick_plain());
               pattern_chars.push_back(delim);
               pattern_chars.push_back(brx_pkg::ChCloseBrk);
            end
            1: begin
               pattern_chars.push_back(brx_pkg::ChOpenBrk);
               pattern_chars.push_back(pick_any());
            end
            default: begin
               pattern_chars.push_back(pick_any());
            end
         endcase
      end
      // now and then left open
      if ($urandom_range(0, 9) != 0) pattern_chars.push_back(brx_pkg::ChCloseBrk);
   endfunction

   function automatic void add_fragment();
      case ($urandom_range(0, 7))
         0: pattern_chars.push_back(pick_plain());
         1: begin
            pattern_chars.push_back(brx_pkg::ChBackslash);
            pattern_chars.push_back(pick_any());
         end
         2: add_bracket();
         3: begin
            pattern_chars.push_back(brx_pkg::ChDollar);
            case ($urandom_range(0, 3))
               0: begin
                  pattern_chars.push_back(brx_pkg::ChBackslash);
                  pattern_chars.push_back(brx_pkg::ChClosePar);
               end
               1: begin
                  pattern_chars.push_back(brx_pkg::ChBackslash);
                  pattern_chars.push_back($urandom_range(0, 1) ?
                                          brx_pkg::ChLess : brx_pkg::ChGreater);
               end
               2: pattern_chars.push_back(pick_any());
               default: ;
            endcase
         end
         4: begin
            pattern_chars.push_back(brx_pkg::ChBackslash);
            pattern_chars.push_back(brx_pkg::ChOpenPar);
            if ($urandom_range(0, 1)) pattern_chars.push_back(brx_pkg::ChCaret);
            if ($urandom_range(0, 1)) pattern_chars.push_back(brx_pkg::ChStar);
         end
         5: begin
            pattern_chars.push_back(brx_pkg::ChBackslash);
            pattern_chars.push_back($urandom_range(0, 1) ?
                                    brx_pkg::ChLess : brx_pkg::ChGreater);
         end
         default: pattern_chars.push_back(pick_special());
      endcase
   endfunction

   task automatic send_random_pattern();
      pattern_chars.delete();
      repeat ($urandom_range(1, 6)) add_fragment();
      for (int i = 0; i < pattern_chars.size(); i++) begin
         send_char(pattern_chars[i], i == pattern_chars.size() - 1);
         random_sent++;
      end
   endtask

   task automatic test_anchors_and_groups();
      send_text("^*\\(^*", 1'b1);
   endtask

   task automatic test_dollar_and_word_boundary();
      send_text("$\\)\\<$", 1'b1);
      // longest run: escaped dollar then a word boundary
      send_text("$\\<", 1'b1);
   endtask

   task automatic test_bracket_forms();
      send_text("[[.].x.]]", 1'b1);
   endtask

   task automatic test_unterminated_and_extremes();
      // inner open bracket swallows the close bracket, pattern ends inside
      send_text("[[]", 1'b0);
      send_char(brx_pkg::char_type'(21'h1FFFFF), 1'b1);
      send_char('0, 1'b0);
      send_char(brx_pkg::ChBackslash, 1'b1);
   endtask

   task automatic test_random_patterns();
      logic drained;
      drained = 1'b0;
      while (random_sent < 180) begin
         steady = (random_sent >= 70 && random_sent < 130);
         if (!drained && random_sent >= 150) begin
            drained = 1'b1;
            req_valid <= 1'b0;
            @(negedge clock);
            while (pending_words.size() != 0) @(negedge clock);
         end
         send_random_pattern();
      end
      steady = 1'b0;
   endtask

   initial begin
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_anchors_and_groups();
      test_dollar_and_word_boundary();
      test_bracket_forms();
      test_unterminated_and_extremes();
      test_random_patterns();
      req_valid <= 1'b0;
      while (pending_words.size() != 0) @(posedge clock);
      repeat (16) @(posedge clock);
      if (mismatch_count == 0 && pending_words.size() == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule

/* basic_to_extended_regex_translator.f */
sv/brx_pkg.sv
sv/brx_xlate.sv
sv/brx_emit.sv
sv/basic_to_extended_regex_translator.sv
tb/sv/basic_to_extended_regex_translator_tb.sv
